>>> sv/hsvrgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared types and constants for the HSV to RGB converter pipeline.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    localparam int HUE_W  = 9;
    localparam int PCT_W  = 7;
    localparam int CH_W   = 8;
    localparam int QUO_W  = 4;
    localparam int FR_W   = 6;
    localparam int K_W    = 14;
    localparam int NUM_W  = 20;
    localparam int PROD_W = 44;
    localparam int NSTG   = 7;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // hue / 60 as (hue * 1093) >> 16, exact for 9-bit hue
    localparam logic [10:0] RECIP_60 = 11'd1093;
    localparam int          RECIP_SH = 16;

    // floor(n * 255 / 600000) as (n * ceil(17 * 2^35 / 40000)) >> 35, exact for n < 2^20
    localparam logic [23:0] SCALE_C  = 24'd14602889;
    localparam int          SCALE_SH = 35;

    localparam logic [K_W-1:0]  K_FULL  = K_W'(6000);
    localparam logic [7:0]      PCT_MAX = 8'd100;
    localparam logic [K_W-1:0]  PCT_SC  = K_W'(60);
    localparam logic [FR_W-1:0] SEC_LEN = FR_W'(60);
    localparam logic [CH_W-1:0] CH_MAX  = {CH_W{1'b1}};

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } t_hue_sector;

    typedef struct packed {
        logic en_num;
        logic en_prod;
        logic en_chan;
    } t_chan_ctl;

endpackage

>>> sv/hsvrgb_chan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_chan
// Three-stage channel scaler: brightness times weight, clamp at zero,
// scale by 255/600000 and saturate to 8 bits.
// ----------------------------------------------------------------------------
module hsvrgb_chan (
    input  logic                              i_clk,
    input  hsvrgb_pkg::t_chan_ctl             i_ctl,
    input  logic [hsvrgb_pkg::PCT_W-1:0]      i_bri,
    input  logic signed [hsvrgb_pkg::K_W-1:0] i_k,
    output logic [hsvrgb_pkg::CH_W-1:0]       o_chan
);
    import hsvrgb_pkg::*;

    logic signed [NUM_W:0]  n_prod_bk;
    logic [NUM_W-1:0]       n_num;
    logic [NUM_W-1:0]       r_num;
    logic [PROD_W-1:0]      r_prod;
    logic [CH_W:0]          n_scaled;
    logic [CH_W-1:0]        r_chan;

    always_comb begin
        n_prod_bk = $signed({{(NUM_W-PCT_W){1'b0}}, i_bri}) * (NUM_W+1)'(i_k);
        n_num     = (n_prod_bk <= 0) ? '0 : n_prod_bk[NUM_W-1:0];
        n_scaled  = r_prod[SCALE_SH +: CH_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_num) begin
            r_num <= n_num;
        end
        if (i_ctl.en_prod) begin
            r_prod <= PROD_W'(r_num) * PROD_W'(SCALE_C);
        end
        if (i_ctl.en_chan) begin
            r_chan <= n_scaled[CH_W] ? CH_MAX : n_scaled[CH_W-1:0];
        end
    end

    assign o_chan = r_chan;

endmodule

>>> sv/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Hexcone HSV to RGB conversion with exact integer arithmetic.
// ----------------------------------------------------------------------------
// Input stream: one request per beat on the s_ channel, tdata holds hue
// (9 bits, degrees), saturation and brightness (7 bits each, percent).
// Output stream: one result per request on the m_ channel, tdata holds
// red, green and blue (8 bits each), truncated toward zero.
// Stages from input handshake to o_m_tvalid, in order: hue divide by
// reciprocal, sector and fraction, channel weights, brightness multiply,
// 255/600000 scaling multiply, saturate, sector select.
// Throughput is one request per cycle unless stalled. Every stage has its
// own valid bit and loads when it is empty or the stage after it moves, so
// bubbles collapse and o_s_tready stays high while any stage is free.
// When the receiver holds i_m_tready low the result stays on o_m_tdata and
// the pipeline keeps filling; once all 7 stages are full o_s_tready drops.
// Synchronous reset (i_rst_n low) clears all valid bits; data registers
// are not reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [hsvrgb_pkg::IN_TDATA_W-1:0]     i_s_tdata,  // hue, saturation, brightness
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [hsvrgb_pkg::OUT_TDATA_W-1:0]    o_m_tdata   // red, green, blue
);
    import hsvrgb_pkg::*;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    logic [HUE_W-1:0]          in_hue;
    logic [PCT_W-1:0]          in_sat;
    logic [PCT_W-1:0]          in_bri;
    logic [HUE_W+10:0]         n_hq;

    // stage 1
    logic [HUE_W-1:0]          r_hue1;
    logic [PCT_W-1:0]          r_sat1;
    logic [PCT_W-1:0]          r_bri1;
    logic [QUO_W-1:0]          r_quo1;
    // stage 2
    logic [FR_W-1:0]           n_fr;
    logic [2:0]                n_sec;
    logic [FR_W-1:0]           r_fr2;
    t_hue_sector               r_sec2;
    logic [PCT_W-1:0]          r_sat2;
    logic [PCT_W-1:0]          r_bri2;
    // stage 3
    logic signed [7:0]         n_ps;
    logic [12:0]               n_fs;
    logic [12:0]               n_gs;
    logic signed [K_W-1:0]     r_kp3;
    logic signed [K_W-1:0]     r_kq3;
    logic signed [K_W-1:0]     r_kt3;
    logic [PCT_W-1:0]          r_bri3;
    t_hue_sector               r_sec3;
    // stages 4..6 inside channel units
    t_hue_sector               r_sec4;
    t_hue_sector               r_sec5;
    t_hue_sector               r_sec6;
    t_chan_ctl                 chan_ctl;
    logic [CH_W-1:0]           ch_v;
    logic [CH_W-1:0]           ch_p;
    logic [CH_W-1:0]           ch_q;
    logic [CH_W-1:0]           ch_t;
    // stage 7
    logic [CH_W-1:0]           n_red;
    logic [CH_W-1:0]           n_green;
    logic [CH_W-1:0]           n_blue;
    logic [CH_W-1:0]           r_red;
    logic [CH_W-1:0]           r_green;
    logic [CH_W-1:0]           r_blue;

    assign in_hue = i_s_tdata[HUE_W-1:0];
    assign in_sat = i_s_tdata[HUE_W +: PCT_W];
    assign in_bri = i_s_tdata[HUE_W+PCT_W +: PCT_W];

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_m_tready;
        for (int i = NSTG-2; i >= 0; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    assign o_s_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // stage 1: quotient hue / 60
    assign n_hq = (HUE_W+11)'(in_hue) * (HUE_W+11)'(RECIP_60);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_hue1 <= in_hue;
            r_sat1 <= in_sat;
            r_bri1 <= in_bri;
            r_quo1 <= n_hq[RECIP_SH +: QUO_W];
        end
    end

    // stage 2: fraction and sector
    always_comb begin
        n_fr  = FR_W'(r_hue1 - HUE_W'(r_quo1) * HUE_W'(SEC_LEN));
        n_sec = (r_quo1 >= QUO_W'(6)) ? 3'(r_quo1 - QUO_W'(6)) : 3'(r_quo1);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_fr2  <= n_fr;
            r_sec2 <= t_hue_sector'(n_sec);
            r_sat2 <= r_sat1;
            r_bri2 <= r_bri1;
        end
    end

    // stage 3: channel weights over denominator 6000
    always_comb begin
        n_ps = $signed(PCT_MAX) - $signed({1'b0, r_sat2});
        n_fs = 13'(r_fr2) * 13'(r_sat2);
        n_gs = 13'(SEC_LEN - r_fr2) * 13'(r_sat2);
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_kp3  <= K_W'(n_ps) * $signed(PCT_SC);
            r_kq3  <= $signed(K_FULL) - $signed({1'b0, n_fs});
            r_kt3  <= $signed(K_FULL) - $signed({1'b0, n_gs});
            r_bri3 <= r_bri2;
            r_sec3 <= r_sec2;
        end
    end

    assign chan_ctl.en_num  = en[3];
    assign chan_ctl.en_prod = en[4];
    assign chan_ctl.en_chan = en[5];

    hsvrgb_chan u_chan_v (
        .i_clk  (i_clk),
        .i_ctl  (chan_ctl),
        .i_bri  (r_bri3),
        .i_k    ($signed(K_FULL)),
        .o_chan (ch_v)
    );

    hsvrgb_chan u_chan_p (
        .i_clk  (i_clk),
        .i_ctl  (chan_ctl),
        .i_bri  (r_bri3),
        .i_k    (r_kp3),
        .o_chan (ch_p)
    );

    hsvrgb_chan u_chan_q (
        .i_clk  (i_clk),
        .i_ctl  (chan_ctl),
        .i_bri  (r_bri3),
        .i_k    (r_kq3),
        .o_chan (ch_q)
    );

    hsvrgb_chan u_chan_t (
        .i_clk  (i_clk),
        .i_ctl  (chan_ctl),
        .i_bri  (r_bri3),
        .i_k    (r_kt3),
        .o_chan (ch_t)
    );

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_sec4 <= r_sec3;
        end
        if (en[4]) begin
            r_sec5 <= r_sec4;
        end
        if (en[5]) begin
            r_sec6 <= r_sec5;
        end
    end

    // stage 7: hexcone sector table
    always_comb begin
        case (r_sec6)
            SEC_RY: begin
                n_red = ch_v; n_green = ch_t; n_blue = ch_p;
            end
            SEC_YG: begin
                n_red = ch_q; n_green = ch_v; n_blue = ch_p;
            end
            SEC_GC: begin
                n_red = ch_p; n_green = ch_v; n_blue = ch_t;
            end
            SEC_CB: begin
                n_red = ch_p; n_green = ch_q; n_blue = ch_v;
            end
            SEC_BM: begin
                n_red = ch_t; n_green = ch_p; n_blue = ch_v;
            end
            default: begin
                n_red = ch_v; n_green = ch_p; n_blue = ch_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tdata  = {r_blue, r_green, r_red};

endmodule

>>> sv/hsvrgb_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_chk
// Port-level checks for the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsvrgb_chk (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  o_s_tready,
    input  logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    input  logic [hsvrgb_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked with empty output stage");

endmodule

bind hsv_to_rgb_converter hsvrgb_chk u_hsvrgb_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

>>> verif/hsv_to_rgb_converter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_test
// Self-checking bench for the hexcone HSV to RGB converter.
// ----------------------------------------------------------------------------
// A short table of fixed colors runs first: black, white, the six primaries
// and secondaries, the 360 degree wrap and the saturating extremes. Later
// come hues past 360 and percents past 100. The random part that follows is
// mostly nominal colors, with sector-edge and full-width values mixed in.
// Each accepted request gets its expected RGB from an integer hexcone
// model or the table. Each result is checked in order against the oldest
// expectation. Both stream sides idle at random, with one stretch held
// busy. The sender also pauses once mid-run until the pipeline has drained.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_test;
    import hsvrgb_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RANDOM_COLORS = 1850;
    localparam int IDLE_PCT      = 37;
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 2 * NSTG + 4;
    localparam int MAX_REPORTS   = 10;
    localparam int N_DIRECTED    = 25;
    localparam longint FULL_SCALE = 600000;   // 100 * 100 * 60

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] bri;
        logic             known;    // rgb below is exact, else use the model
        t_rgb             rgb;
    } t_color_row;

    localparam t_color_row DIRECTED [N_DIRECTED] = '{
        '{9'd0,   7'd0,   7'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
        '{9'd0,   7'd0,   7'd100, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{9'd0,   7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd0}},
        '{9'd60,  7'd100, 7'd100, 1'b1, '{8'd255, 8'd255, 8'd0}},
        '{9'd120, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd255, 8'd0}},
        '{9'd180, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd255, 8'd255}},
        '{9'd240, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd0,   8'd255}},
        '{9'd300, 7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd255}},
        '{9'd360, 7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd0}},
        '{9'd0,   7'd127, 7'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
        '{9'd0,   7'd0,   7'd127, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{9'd30,  7'd100, 7'd100, 1'b0, '0},
        '{9'd90,  7'd50,  7'd100, 1'b0, '0},
        '{9'd150, 7'd75,  7'd60,  1'b0, '0},
        '{9'd210, 7'd25,  7'd40,  1'b0, '0},
        '{9'd270, 7'd100, 7'd1,   1'b0, '0},
        '{9'd330, 7'd60,  7'd99,  1'b0, '0},
        '{9'd359, 7'd100, 7'd100, 1'b0, '0},
        '{9'd361, 7'd80,  7'd80,  1'b0, '0},
        '{9'd420, 7'd100, 7'd100, 1'b0, '0},
        '{9'd511, 7'd127, 7'd127, 1'b0, '0},
        '{9'd479, 7'd1,   7'd127, 1'b0, '0},
        '{9'd256, 7'd127, 7'd100, 1'b0, '0},
        '{9'd85,  7'd101, 7'd50,  1'b0, '0},
        '{9'd0,   7'd100, 7'd1,   1'b0, '0}
    };

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;    // hue, saturation, brightness
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;          // red, green, blue

    t_rgb next_rgb = '0;
    t_rgb rgb_due_q[$];
    bit   steady = 1'b0;
    int   errors = 0;
    int   colors_sent = 0;
    int   past_range = 0;
    int   results_checked = 0;
    int   stall_cycles = 0;

    hsv_to_rgb_converter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic logic [CH_W-1:0] scale_to_byte(input longint numer);
        longint level;
        if (numer <= 0) begin
            return '0;
        end
        level = numer * 255 / FULL_SCALE;
        if (level > 255) begin
            return CH_MAX;
        end
        return CH_W'(level);
    endfunction

    // hexcone conversion, all terms kept as numerators over FULL_SCALE
    function automatic t_rgb hexcone_rgb(input logic [HUE_W-1:0] hue,
                                         input logic [PCT_W-1:0] sat,
                                         input logic [PCT_W-1:0] bri);
        longint      h;
        longint      s;
        longint      b;
        longint      f;
        t_hue_sector sector;
        logic [CH_W-1:0] v;
        logic [CH_W-1:0] p;
        logic [CH_W-1:0] q;
        logic [CH_W-1:0] t;
        t_rgb        c;
        h = longint'(hue);
        s = longint'(sat);
        b = longint'(bri);
        sector = t_hue_sector'(3'((h / 60) % 6));
        f = h % 60;
        v = scale_to_byte(b * 6000);
        p = scale_to_byte(b * (100 - s) * 60);
        q = scale_to_byte(b * (6000 - f * s));
        t = scale_to_byte(b * (6000 - (60 - f) * s));
        case (sector)
            SEC_RY: c = '{red: v, green: t, blue: p};
            SEC_YG: c = '{red: q, green: v, blue: p};
            SEC_GC: c = '{red: p, green: v, blue: t};
            SEC_CB: c = '{red: p, green: q, blue: v};
            SEC_BM: c = '{red: t, green: p, blue: v};
            default: c = '{red: v, green: p, blue: q};
        endcase
        return c;
    endfunction

    function automatic logic [PCT_W-1:0] edge_pct();
        case ($urandom_range(4))
            0: return PCT_W'(0);
            1: return PCT_W'(1);
            2: return PCT_W'(99);
            3: return PCT_W'(100);
            default: return PCT_W'(127);
        endcase
    endfunction

    // inputs move on the falling edge; caller sits just after one
    task automatic send_color(input logic [HUE_W-1:0] hue, input logic [PCT_W-1:0] sat,
                              input logic [PCT_W-1:0] bri, input t_rgb want);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {1'b0, bri, sat, hue};
        next_rgb   = want;
        colors_sent++;
        if (hue > 360 || sat > 100 || bri > 100) begin
            past_range++;
        end
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        i_s_tvalid = 1'b0;
        while (rgb_due_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    always @(negedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin : scoreboard
        t_rgb seen;
        t_rgb due;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                rgb_due_q.push_back(next_rgb);
            end
            if (o_m_tvalid && i_m_tready) begin
                seen = '{red:   o_m_tdata[CH_W-1:0],
                         green: o_m_tdata[2*CH_W-1:CH_W],
                         blue:  o_m_tdata[3*CH_W-1:2*CH_W]};
                results_checked++;
                if (rgb_due_q.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("%0t: unexpected result r=%0d g=%0d b=%0d", $realtime,
                                 seen.red, seen.green, seen.blue);
                    end
                end else begin
                    due = rgb_due_q.pop_front();
                    if (seen.red !== due.red || seen.green !== due.green ||
                        seen.blue !== due.blue) begin
                        errors++;
                        if (errors <= MAX_REPORTS) begin
                            $display("%0t: rgb mismatch, want %0d/%0d/%0d got %0d/%0d/%0d",
                                     $realtime, due.red, due.green, due.blue,
                                     seen.red, seen.green, seen.blue);
                        end
                    end
                end
            end
            if (!(i_s_tvalid && o_s_tready) && !(o_m_tvalid && i_m_tready)) begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                             $realtime, stall_cycles, rgb_due_q.size());
                    $display("*** FAILED ***");
                    $finish;
                end
            end else begin
                stall_cycles = 0;
            end
        end
    end

    initial begin : stimulus
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] bri;
        int               pick;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_color(DIRECTED[i].hue, DIRECTED[i].sat, DIRECTED[i].bri,
                       DIRECTED[i].known ? DIRECTED[i].rgb
                                         : hexcone_rgb(DIRECTED[i].hue, DIRECTED[i].sat,
                                                       DIRECTED[i].bri));
        end
        wait_results_drained();

        for (int n = 0; n < RANDOM_COLORS; n++) begin
            steady = (n >= 700 && n < 1000);
            if (n == 1300) begin
                wait_results_drained();
            end
            pick = $urandom_range(99);
            if (pick < 75) begin
                hue = HUE_W'($urandom_range(360));
                sat = PCT_W'($urandom_range(100));
                bri = PCT_W'($urandom_range(100));
            end else if (pick < 88) begin
                // sector edges, one degree either side
                hue = HUE_W'(60 * $urandom_range(8) + $urandom_range(2) - 1);
                sat = edge_pct();
                bri = edge_pct();
            end else begin
                hue = HUE_W'($urandom);
                sat = PCT_W'($urandom);
                bri = PCT_W'($urandom);
            end
            send_color(hue, sat, bri, hexcone_rgb(hue, sat, bri));
        end
        steady = 1'b0;

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d colors (%0d table rows), %0d with a field past its nominal range;",
                 colors_sent, N_DIRECTED, past_range);
        $display("checked %0d results, %0d mismatches.", results_checked, errors);
        if (errors == 0 && rgb_due_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
